// ----- rtl/core/i2cscb_pkg.sv -----
// shared types, command codes and constants of the checksummed i2c slave buffer
`timescale 1ns / 1ps

package i2cscb_pkg;

   // bus event codes carried in the request tuser
   localparam logic [2:0] CMD_ADDR = 3'd0;
   localparam logic [2:0] CMD_DATA = 3'd1;
   localparam logic [2:0] CMD_COLL = 3'd2;
   localparam logic [2:0] CMD_OVFL = 3'd3;
   localparam logic [2:0] CMD_LOAD = 3'd4;

   // latched error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_COLL = 2'd1;
   localparam logic [1:0] ERR_OVFL = 2'd2;

   // checksum term mask and status table depth
   localparam logic [7:0] CHK_MASK     = 8'hAA;
   localparam int         STATUS_SLOTS = 21;

   // parameter defaults
   localparam int TX_LEN_DEF   = 22;
   localparam int RX_LEN_DEF   = 8;
   localparam int BUF_SIZE_DEF = 32;

   // control of the shared checksum accumulator
   typedef struct packed {
      logic       clear;
      logic       add;
      logic [7:0] data_val;
      logic [4:0] pos;
   } chk_ctl_type;

   // one result word
   typedef struct packed {
      logic [1:0] error_code;
      logic       frame_ok;
      logic [7:0] tx_byte;
      logic       tx_valid;
   } rsp_item_type;

endpackage

// ----- rtl/core/i2cscb_frame_ram.sv -----
// frame buffer memory, one write port and one registered read port
`timescale 1ns / 1ps

module i2cscb_frame_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/i2cscb_chk_unit.sv -----
// shared checksum accumulator: adds ((byte + position) xor mask) per step
`timescale 1ns / 1ps

module i2cscb_chk_unit
   import i2cscb_pkg::*;
(
   input  logic        clock,
   input  chk_ctl_type ctl,
   output logic [7:0]  acc
);

   logic [7:0] acc_ff;
   logic [7:0] acc_in;
   logic [7:0] term;

   // one checksum term, all mod 256
   assign term = (ctl.data_val + {3'b000, ctl.pos}) ^ CHK_MASK;

   always_comb begin
      priority if (ctl.clear) begin
         acc_in = 8'h00;
      end else if (ctl.add) begin
         acc_in = acc_ff + term;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- rtl/core/i2cscb_ctrl.sv -----
// sequencer: event decode, status table, buffer index and checksum walks
`timescale 1ns / 1ps

module i2cscb_ctrl
   import i2cscb_pkg::*;
#(
   parameter int TX_LEN   = TX_LEN_DEF,
   parameter int RX_LEN   = RX_LEN_DEF,
   parameter int BUF_SIZE = BUF_SIZE_DEF,
   parameter int AW       = $clog2(BUF_SIZE)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_fire,
   input  logic [2:0]    req_cmd,
   input  logic          req_rw,
   input  logic [7:0]    req_data_byte,
   input  logic [4:0]    req_slot,
   output logic          ready,
   input  logic          out_free,
   output logic          res_valid,
   output rsp_item_type  res,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output logic [7:0]    mem_wr_data,
   output logic [AW-1:0] mem_rd_addr,
   input  logic [7:0]    mem_rd_data,
   output chk_ctl_type   chk_ctl,
   input  logic [7:0]    chk_acc
);

   localparam int IW = 6;

   // sequencer states
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_COPY     = 4'd1;
   localparam logic [3:0] ST_SUM      = 4'd2;
   localparam logic [3:0] ST_SUM_END  = 4'd3;
   localparam logic [3:0] ST_RX_RD    = 4'd4;
   localparam logic [3:0] ST_RX_CMP   = 4'd5;
   localparam logic [3:0] ST_CHK_WR   = 4'd6;
   localparam logic [3:0] ST_SEND     = 4'd7;
   localparam logic [3:0] ST_SEND_CAP = 4'd8;
   localparam logic [3:0] ST_RESP     = 4'd9;

   localparam logic [4:0] COPY_LAST = 5'(STATUS_SLOTS - 1);
   localparam logic [4:0] TX_LAST_K = 5'(TX_LEN - 2);
   localparam logic [4:0] RX_LAST_K = 5'(RX_LEN - 2);

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          tmode_ff, tmode_in;
   logic [1:0]    err_ff, err_in;
   logic [4:0]    k_ff, k_in;
   logic [4:0]    kd_ff;
   logic          pend_ff, pend_in;
   logic          is_tx_ff, is_tx_in;
   logic          tx_valid_ff, tx_valid_in;
   logic [7:0]    tx_byte_ff, tx_byte_in;
   logic          frame_ok_ff, frame_ok_in;
   logic [7:0]    status_ff [STATUS_SLOTS];
   logic          acc_clear;

   // clamp an index onto the buffer, out of range reads land on the last entry
   function automatic logic [AW-1:0] buf_addr(input logic [IW-1:0] idx);
      if (int'(idx) < BUF_SIZE) begin
         return idx[AW-1:0];
      end else begin
         return AW'(BUF_SIZE - 1);
      end
   endfunction

   assign ready     = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_RESP);

   // next state and datapath control
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      tmode_in    = tmode_ff;
      err_in      = err_ff;
      k_in        = k_ff;
      pend_in     = 1'b0;
      is_tx_in    = is_tx_ff;
      tx_valid_in = tx_valid_ff;
      tx_byte_in  = tx_byte_ff;
      frame_ok_in = frame_ok_ff;
      acc_clear   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = buf_addr(idx_ff);
      mem_wr_data = req_data_byte;
      mem_rd_addr = buf_addr(idx_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               tx_valid_in = 1'b0;
               tx_byte_in  = 8'h00;
               frame_ok_in = 1'b0;
               state_in    = ST_RESP;
               unique case (req_cmd)
                  CMD_ADDR: begin
                     tmode_in = req_rw;
                     idx_in   = '0;
                     if (req_rw) begin
                        k_in     = '0;
                        state_in = ST_COPY;
                     end
                  end
                  CMD_DATA: begin
                     if (tmode_ff) begin
                        if (req_rw) begin
                           state_in = ST_SEND;
                        end else begin
                           idx_in = '0;
                        end
                     end else if (int'(idx_ff) < RX_LEN) begin
                        mem_wr_en = (int'(idx_ff) < BUF_SIZE);
                        idx_in    = idx_ff + IW'(1);
                        if (int'(idx_ff) + 1 == RX_LEN) begin
                           is_tx_in  = 1'b0;
                           k_in      = '0;
                           acc_clear = 1'b1;
                           state_in  = ST_SUM;
                        end
                     end
                  end
                  CMD_COLL, CMD_OVFL: begin
                     err_in   = (req_cmd == CMD_COLL) ? ERR_COLL : ERR_OVFL;
                     tmode_in = 1'b0;
                     idx_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // status table into the buffer, one slot a cycle
         ST_COPY: begin
            mem_wr_en   = (int'(k_ff) < BUF_SIZE);
            mem_wr_addr = buf_addr({1'b0, k_ff});
            mem_wr_data = status_ff[k_ff];
            if (k_ff == COPY_LAST) begin
               k_in      = '0;
               is_tx_in  = 1'b1;
               acc_clear = 1'b1;
               state_in  = ST_SUM;
            end else begin
               k_in = k_ff + 5'd1;
            end
         end
         // checksum walk, each read is registered and added in the cycle after it is issued
         ST_SUM: begin
            mem_rd_addr = buf_addr({1'b0, k_ff});
            pend_in     = 1'b1;
            if (k_ff == (is_tx_ff ? TX_LAST_K : RX_LAST_K)) begin
               state_in = ST_SUM_END;
            end else begin
               k_in = k_ff + 5'd1;
            end
         end
         ST_SUM_END: begin
            state_in = is_tx_ff ? ST_CHK_WR : ST_RX_RD;
         end
         ST_RX_RD: begin
            mem_rd_addr = buf_addr(IW'(RX_LEN - 1));
            state_in    = ST_RX_CMP;
         end
         ST_RX_CMP: begin
            frame_ok_in = (mem_rd_data == chk_acc);
            state_in    = ST_RESP;
         end
         ST_CHK_WR: begin
            mem_wr_en   = (TX_LEN - 1 < BUF_SIZE);
            mem_wr_addr = buf_addr(IW'(TX_LEN - 1));
            mem_wr_data = chk_acc;
            idx_in      = '0;
            state_in    = ST_SEND;
         end
         // read the byte at the index, hold on the checksum byte
         ST_SEND: begin
            mem_rd_addr = buf_addr(idx_ff);
            if (int'(idx_ff) + 1 < TX_LEN) begin
               idx_in = idx_ff + IW'(1);
            end
            state_in = ST_SEND_CAP;
         end
         ST_SEND_CAP: begin
            tx_valid_in = 1'b1;
            tx_byte_in  = mem_rd_data;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // checksum unit drive
   assign chk_ctl.clear    = acc_clear;
   assign chk_ctl.add      = pend_ff;
   assign chk_ctl.data_val = mem_rd_data;
   assign chk_ctl.pos      = kd_ff;

   // result word
   assign res.tx_valid   = tx_valid_ff;
   assign res.tx_byte    = tx_byte_ff;
   assign res.frame_ok   = frame_ok_ff;
   assign res.error_code = err_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         tmode_ff <= 1'b0;
         err_ff   <= ERR_NONE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         tmode_ff <= tmode_in;
         err_ff   <= err_in;
         pend_ff  <= pend_in;
      end
   end

   // status table, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STATUS_SLOTS; i++) begin
            status_ff[i] <= 8'h00;
         end
      end else if (ready && req_fire && req_cmd == CMD_LOAD &&
                   int'(req_slot) < STATUS_SLOTS) begin
         status_ff[req_slot] <= req_data_byte;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      kd_ff       <= k_ff;
      is_tx_ff    <= is_tx_in;
      tx_valid_ff <= tx_valid_in;
      tx_byte_ff  <= tx_byte_in;
      frame_ok_ff <= frame_ok_in;
   end

endmodule

// ----- rtl/core/i2c_slave_checksummed_buffer.sv -----
// top level: request/response streams, output register, sequencer, buffer and checksum unit
`timescale 1ns / 1ps

// Checksummed frame buffer that sits behind a byte-level I2C slave. Each request
// word is one bus event and gives exactly one response word. The block takes one
// word at a time and drops req_tready while it works; a finished response waits
// in an output register, so the next request can be taken while it is stalled.
// A read address copies the status table into the buffer, walks the checksum
// over the frame, writes the checksum byte and then reads the first byte; the
// received byte that completes a frame starts a checksum walk and a compare. The
// status copy (21 slots, one a cycle) and the checksum walk (one byte a cycle
// through one shared accumulator) go in turn through the buffer's single write
// port and single read port. The frame buffer needs no clearing after reset.

module i2c_slave_checksummed_buffer
   import i2cscb_pkg::*;
#(
   parameter int TX_LEN   = TX_LEN_DEF,
   parameter int RX_LEN   = RX_LEN_DEF,
   parameter int BUF_SIZE = BUF_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // rw, data_byte, slot, zero fill
   input  logic [2:0]  req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // tx_valid, tx_byte, frame_ok, error_code, zero fill
);

   localparam int AW = $clog2(BUF_SIZE);

   logic          req_fire;
   logic          out_free;
   logic          res_valid;
   rsp_item_type  res;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;
   chk_ctl_type   chk_ctl;
   logic [7:0]    chk_acc;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff;
   logic          busy;
   logic          busy_n;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = !busy;

   i2cscb_ctrl #(
      .TX_LEN   (TX_LEN),
      .RX_LEN   (RX_LEN),
      .BUF_SIZE (BUF_SIZE),
      .AW       (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .req_cmd       (req_tuser),
      .req_rw        (req_tdata[0]),
      .req_data_byte (req_tdata[8:1]),
      .req_slot      (req_tdata[13:9]),
      .ready         (busy_n),
      .out_free      (out_free),
      .res_valid     (res_valid),
      .res           (res),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .chk_ctl       (chk_ctl),
      .chk_acc       (chk_acc)
   );

   assign busy = !busy_n;

   i2cscb_frame_ram #(
      .DEPTH (BUF_SIZE),
      .AW    (AW)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   i2cscb_chk_unit u_chk_unit (
      .clock (clock),
      .ctl   (chk_ctl),
      .acc   (chk_acc)
   );

   // output register, loaded when the slot is free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_item_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_item_ff};

`ifndef ASSERT_OFF
   // the sequencer is busy right after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted while sequencer still busy");

   // no byte is sent without a transmit strobe
   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_item_ff.tx_valid |-> rsp_item_ff.tx_byte == 8'h00)
      else $error("tx byte nonzero without tx strobe");

   // a frame check never coincides with a transmitted byte
   a_ok_not_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_item_ff.tx_valid && rsp_item_ff.frame_ok))
      else $error("frame_ok together with tx_valid");

   // a collision report shows up in the response it causes
   a_coll_latched: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == CMD_COLL |=> ##1 res.error_code == ERR_COLL)
      else $error("collision not latched");
`endif

endmodule

// ----- sim/tb_top.sv -----
// testbench for the checksummed i2c slave buffer: table-driven and random bus events
`timescale 1ns / 1ps

module tb_top;
   import i2cscb_pkg::*;

   localparam int TX_LEN   = TX_LEN_DEF;
   localparam int RX_LEN   = RX_LEN_DEF;
   localparam int BUF_SIZE = BUF_SIZE_DEF;

   // spare event codes the block ignores
   localparam logic [2:0] CMD_SPARE5 = 3'd5;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   localparam int N_DIRECTED   = 24;
   localparam int N_RANDOM     = 1450;
   localparam int DRAIN_CYCLES = 60;

   // one bus event; reply is used only when fixed is set
   typedef struct packed {
      logic [2:0]   cmd;
      logic         rw;
      logic [7:0]   data;
      logic [4:0]   slot;
      logic         fixed;
      rsp_item_type reply;
   } bus_word_type;

   localparam rsp_item_type NO_REPLY = '0;

   // directed events: spare codes, ack/nack, status loads at the slot extremes,
   // all-ones frame with matching checksum, byte past the frame, both errors
   localparam bus_word_type DIRECTED_WORDS [N_DIRECTED] = '{
      '{CMD_SPARE5, 1'b1, 8'hFF, 5'd31, 1'b1, NO_REPLY},
      '{CMD_SPARE7, 1'b0, 8'h00, 5'd0,  1'b1, NO_REPLY},
      '{CMD_ADDR,   1'b1, 8'h00, 5'd0,  1'b1, '{ERR_NONE, 1'b0, 8'h00, 1'b1}},
      '{CMD_DATA,   1'b1, 8'hFF, 5'd31, 1'b1, '{ERR_NONE, 1'b0, 8'h00, 1'b1}},
      '{CMD_DATA,   1'b0, 8'h00, 5'd0,  1'b1, NO_REPLY},
      '{CMD_LOAD,   1'b0, 8'hFF, 5'd0,  1'b1, NO_REPLY},
      '{CMD_LOAD,   1'b1, 8'h80, 5'd20, 1'b1, NO_REPLY},
      '{CMD_LOAD,   1'b0, 8'h55, 5'd21, 1'b1, NO_REPLY},
      '{CMD_LOAD,   1'b1, 8'h01, 5'd31, 1'b1, NO_REPLY},
      '{CMD_ADDR,   1'b1, 8'h00, 5'd0,  1'b1, '{ERR_NONE, 1'b0, 8'hFF, 1'b1}},
      '{CMD_DATA,   1'b1, 8'h00, 5'd0,  1'b0, NO_REPLY},
      '{CMD_ADDR,   1'b0, 8'hFF, 5'd31, 1'b1, NO_REPLY},
      '{CMD_DATA,   1'b0, 8'hFF, 5'd0,  1'b0, NO_REPLY},
      '{CMD_DATA,   1'b1, 8'hFF, 5'd0,  1'b0, NO_REPLY},
      '{CMD_DATA,   1'b0, 8'hFF, 5'd0,  1'b0, NO_REPLY},
      '{CMD_DATA,   1'b1, 8'hFF, 5'd0,  1'b0, NO_REPLY},
      '{CMD_DATA,   1'b0, 8'hFF, 5'd0,  1'b0, NO_REPLY},
      '{CMD_DATA,   1'b1, 8'hFF, 5'd0,  1'b0, NO_REPLY},
      '{CMD_DATA,   1'b0, 8'hFF, 5'd0,  1'b0, NO_REPLY},
      '{CMD_DATA,   1'b0, 8'h58, 5'd0,  1'b1, '{ERR_NONE, 1'b1, 8'h00, 1'b0}},
      '{CMD_DATA,   1'b1, 8'h00, 5'd0,  1'b1, NO_REPLY},
      '{CMD_COLL,   1'b0, 8'h00, 5'd0,  1'b1, '{ERR_COLL, 1'b0, 8'h00, 1'b0}},
      '{CMD_ADDR,   1'b1, 8'h00, 5'd0,  1'b1, '{ERR_COLL, 1'b0, 8'hFF, 1'b1}},
      '{CMD_OVFL,   1'b1, 8'hFF, 5'd31, 1'b1, '{ERR_OVFL, 1'b0, 8'h00, 1'b0}}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;  // rw, data_byte, slot, zero fill
   logic [2:0]  req_tuser  = '0;  // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // tx_valid, tx_byte, frame_ok, error_code, zero fill

   bus_word_type bus_word_q [$];
   rsp_item_type reply_q [$];
   int           sent_cnt     = 0;
   int           accepted_cnt = 0;
   int           mismatch_cnt = 0;

   // shadow state of the buffer
   logic [7:0] frame_mem  [BUF_SIZE];
   logic [7:0] status_mem [STATUS_SLOTS];
   logic [5:0] byte_idx   = '0;
   logic       sending    = 1'b0;
   logic [1:0] err_latch  = ERR_NONE;

   i2c_slave_checksummed_buffer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one checksum term: (byte + position) mod 256, masked
   function automatic logic [7:0] chk_term(logic [7:0] b, int k);
      logic [7:0] t;
      t = b + 8'(k);
      return t ^ CHK_MASK;
   endfunction

   // buffer read with out-of-range reads clamped to the last entry
   function automatic logic [7:0] frame_fetch(int idx);
      return (idx < BUF_SIZE) ? frame_mem[idx] : frame_mem[BUF_SIZE - 1];
   endfunction

   function automatic void frame_store(int idx, logic [7:0] v);
      if (idx < BUF_SIZE) frame_mem[idx] = v;
   endfunction

   // checksum over the first count - 1 entries
   function automatic logic [7:0] frame_sum(int count);
      logic [7:0] acc;
      acc = '0;
      for (int k = 0; k + 1 < count; k++) acc = acc + chk_term(frame_fetch(k), k);
      return acc;
   endfunction

   // put the current byte on the bus, stop on the checksum byte
   function automatic void send_byte(ref rsp_item_type r);
      r.tx_valid = 1'b1;
      r.tx_byte  = frame_fetch(int'(byte_idx));
      if (int'(byte_idx) + 1 < TX_LEN) byte_idx = byte_idx + 6'd1;
   endfunction

   // advance the shadow state by one bus event and form its reply
   function automatic void apply_bus_word(bus_word_type w, ref rsp_item_type r);
      r = '0;
      case (w.cmd)
         CMD_ADDR: begin
            if (w.rw) begin
               sending = 1'b1;
               for (int k = 0; k < STATUS_SLOTS; k++) frame_store(k, status_mem[k]);
               frame_store(TX_LEN - 1, frame_sum(TX_LEN));
               byte_idx = '0;
               send_byte(r);
            end else begin
               sending  = 1'b0;
               byte_idx = '0;
            end
         end
         CMD_DATA: begin
            if (sending) begin
               if (w.rw) send_byte(r);
               else byte_idx = '0;
            end else if (int'(byte_idx) < RX_LEN) begin
               frame_store(int'(byte_idx), w.data);
               byte_idx = byte_idx + 6'd1;
               if (int'(byte_idx) == RX_LEN && frame_sum(RX_LEN) == frame_fetch(RX_LEN - 1))
                  r.frame_ok = 1'b1;
            end
         end
         CMD_COLL, CMD_OVFL: begin
            err_latch = (w.cmd == CMD_COLL) ? ERR_COLL : ERR_OVFL;
            sending   = 1'b0;
            byte_idx  = '0;
         end
         CMD_LOAD: begin
            if (int'(w.slot) < STATUS_SLOTS) status_mem[w.slot] = w.data;
         end
         default: ;
      endcase
      r.error_code = err_latch;
   endfunction

   function automatic void add_word(logic [2:0] cmd, logic rw, logic [7:0] data, logic [4:0] slot);
      bus_word_type w;
      w       = '0;
      w.cmd   = cmd;
      w.rw    = rw;
      w.data  = data;
      w.slot  = slot;
      bus_word_q.push_back(w);
   endfunction

   function automatic logic [2:0] error_cmd();
      return $urandom_range(1) ? CMD_COLL : CMD_OVFL;
   endfunction

   // write frame: address, bytes, checksum byte; sometimes cut short,
   // broken by an error, carrying a bad checksum or trailing bytes
   function automatic void add_write_frame();
      logic [7:0] b;
      logic [7:0] sum;
      int         n;
      add_word(CMD_ADDR, 1'b0, 8'($urandom), 5'($urandom));
      n = ($urandom_range(9) == 0) ? $urandom_range(RX_LEN - 2) : RX_LEN - 1;
      sum = '0;
      for (int k = 0; k < n; k++) begin
         b   = 8'($urandom);
         sum = sum + chk_term(b, k);
         add_word(CMD_DATA, 1'($urandom), b, 5'($urandom));
         if ($urandom_range(60) == 0) add_word(error_cmd(), 1'($urandom), 8'($urandom), 5'($urandom));
      end
      if (n == RX_LEN - 1) begin
         b = ($urandom_range(6) == 0) ? 8'($urandom) : sum;
         add_word(CMD_DATA, 1'($urandom), b, 5'($urandom));
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) add_word(CMD_DATA, 1'($urandom), 8'($urandom), 5'($urandom));
      end
   endfunction

   // read: address, then acks, some running past the checksum byte, a few nacks
   function automatic void add_read();
      int n;
      add_word(CMD_ADDR, 1'b1, 8'($urandom), 5'($urandom));
      n = ($urandom_range(3) == 0) ? $urandom_range(TX_LEN, TX_LEN + 6) : $urandom_range(8);
      for (int k = 0; k < n; k++)
         add_word(CMD_DATA, ($urandom_range(12) != 0), 8'($urandom), 5'($urandom));
   endfunction

   function automatic void build_stimulus();
      int r;
      for (int i = 0; i < N_DIRECTED; i++) bus_word_q.push_back(DIRECTED_WORDS[i]);
      while (bus_word_q.size() < N_DIRECTED + N_RANDOM) begin
         r = $urandom_range(99);
         if (r < 38) add_write_frame();
         else if (r < 68) add_read();
         else if (r < 85) begin
            repeat ($urandom_range(1, 4))
               add_word(CMD_LOAD, 1'($urandom), 8'($urandom),
                        ($urandom_range(6) == 0) ? 5'($urandom_range(STATUS_SLOTS, 31))
                                                 : 5'($urandom_range(STATUS_SLOTS - 1)));
         end else if (r < 96) begin
            repeat ($urandom_range(1, 3))
               add_word(3'($urandom), 1'($urandom), 8'($urandom), 5'($urandom));
         end else add_word(error_cmd(), 1'($urandom), 8'($urandom), 5'($urandom));
      end
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_cnt++;
      end
   endfunction

   // request driver, with no gaps between words 700 and 1000
   always @(posedge clock) begin : req_driver
      bus_word_type w;
      if (!reset) begin
         if (req_tvalid && req_tready) sent_cnt++;
         if (!req_tvalid || req_tready) begin
            if (sent_cnt < bus_word_q.size() &&
                ((sent_cnt >= 700 && sent_cnt < 1000) || $urandom_range(99) >= 7)) begin
               w = bus_word_q[sent_cnt];
               req_tdata  <= {2'b00, w.slot, w.data, w.rw};
               req_tuser  <= w.cmd;
               req_tvalid <= 1'b1;
            end else req_tvalid <= 1'b0;
         end
      end
   end

   // response sink with one long hold-off to back up the block
   always @(posedge clock) begin : rsp_sink
      int  rsp_seen;
      int  hold_left;
      bit  hold_done;
      if (reset) begin
         rsp_seen  = 0;
         hold_left = 0;
         hold_done = 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rsp_seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_seen >= 300) begin
            hold_done = 1'b1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= (rsp_seen >= 700 && rsp_seen < 1000) || $urandom_range(99) >= 7;
      end
   end

   // predict on every accepted request word, check every accepted response word
   always @(posedge clock) begin : scoreboard
      bus_word_type w;
      rsp_item_type pred;
      rsp_item_type want;
      rsp_item_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            w = bus_word_q[accepted_cnt];
            accepted_cnt++;
            apply_bus_word(w, pred);
            reply_q.push_back(w.fixed ? w.reply : pred);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[11:0];
            if (reply_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %h", $time, rsp_tdata);
               mismatch_cnt++;
            end else begin
               want = reply_q.pop_front();
               check_field("tx_valid", want.tx_valid, got.tx_valid);
               check_field("tx_byte", want.tx_byte, got.tx_byte);
               check_field("frame_ok", want.frame_ok, got.frame_ok);
               check_field("error_code", want.error_code, got.error_code);
            end
         end
      end
   end

   // run control
   initial begin
      for (int k = 0; k < BUF_SIZE; k++) frame_mem[k] = '0;
      for (int k = 0; k < STATUS_SLOTS; k++) status_mem[k] = '0;
      build_stimulus();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (accepted_cnt < bus_word_q.size() || reply_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_cnt == 0 && reply_q.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
